### design/rgba_blend_mode_compositor_core_macros.svh
// Assertion macros for the RGBA blend-mode compositor.
// Checks compile only in simulation; synthesis sees empty bodies.
`ifndef RGBA_BLEND_MODE_COMPOSITOR_CORE_MACROS_SVH
`define RGBA_BLEND_MODE_COMPOSITOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RBMC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbmc check failed");
// next-cycle implication
`define RBMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rbmc check failed");
`else
`define RBMC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define RBMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### design/rbmc_pkg.sv
// Shared widths, codes and the divider lane type for the RGBA compositor.
// No dependencies; used by the interfaces, the divider and the top level.
package rbmc_pkg;

    localparam int CH_W        = 8;
    localparam int NUM_LANES   = 4;
    localparam int COLOR_LANES = 3;
    localparam int LANE_RED    = 0;
    localparam int LANE_GREEN  = 1;
    localparam int LANE_BLUE   = 2;
    localparam int LANE_ALPHA  = 3;

    localparam int MODE_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam int SA_W   = 2 * CH_W;      // scaled alpha, 1/255^2
    localparam int DD_W   = 2 * CH_W;      // d * dst_alpha
    localparam int B_W    = 18;            // signed blend value
    localparam int A_W    = 24;            // output alpha, 1/255^3
    localparam int A511_W = A_W + 9;
    localparam int DR_W   = DD_W + SA_W;
    localparam int P_W    = 35;            // signed premultiplied color
    localparam int N_W    = 33;            // divider remainder
    localparam int D_W    = A_W + 1;       // divider denominator
    localparam int Q_STEPS = CH_W;
    localparam int POS_W  = $clog2(Q_STEPS);

    localparam logic [SA_W-1:0] FULL2          = 16'd65025;
    localparam logic [D_W-1:0]  ALPHA_DEN      = 25'd130050;
    localparam logic [CH_W-1:0] OPACITY_RESET  = 8'd255;

    typedef enum logic [MODE_W-1:0] {
        MODE_NORMAL   = 3'd0,
        MODE_MULTIPLY = 3'd1,
        MODE_SCREEN   = 3'd2,
        MODE_ADD      = 3'd3,
        MODE_SUBTRACT = 3'd4,
        MODE_DARKEN   = 3'd5,
        MODE_LIGHTEN  = 3'd6
    } blend_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLEND_MODE    = 2'd0,
        REG_LAYER_OPACITY = 2'd1
    } cfg_reg_t;

    // One channel in flight through the restoring divider. A fixed lane
    // already holds its final quotient and is skipped by every step.
    typedef struct packed {
        logic            fixed;
        logic [CH_W-1:0] q;
        logic [N_W-1:0]  rem;
        logic [D_W-1:0]  den;
    } div_lane_t;

    function automatic div_lane_t div_step(input div_lane_t l, input logic [POS_W-1:0] pos);
        div_lane_t      r;
        logic [N_W-1:0] shifted;
        r       = l;
        shifted = N_W'(l.den) << pos;
        if (!l.fixed && (l.rem >= shifted))
        begin
            r.rem    = l.rem - shifted;
            r.q[pos] = 1'b1;
        end
        return r;
    endfunction

endpackage

### design/rbmc_if.sv
// Valid/ready channel interfaces: pixel pair in, composited pixel out, config.
// Depends on rbmc_pkg for field widths.
interface rbmc_in_if;
    logic                       valid;
    logic                       ready;
    logic [rbmc_pkg::CH_W-1:0]  dst_red;
    logic [rbmc_pkg::CH_W-1:0]  dst_green;
    logic [rbmc_pkg::CH_W-1:0]  dst_blue;
    logic [rbmc_pkg::CH_W-1:0]  dst_alpha;
    logic [rbmc_pkg::CH_W-1:0]  src_red;
    logic [rbmc_pkg::CH_W-1:0]  src_green;
    logic [rbmc_pkg::CH_W-1:0]  src_blue;
    logic [rbmc_pkg::CH_W-1:0]  src_alpha;

    modport source (output valid, dst_red, dst_green, dst_blue, dst_alpha,
                     src_red, src_green, src_blue, src_alpha, input ready);
    modport sink   (input valid, dst_red, dst_green, dst_blue, dst_alpha,
                     src_red, src_green, src_blue, src_alpha, output ready);
endinterface

interface rbmc_out_if;
    logic                       valid;
    logic                       ready;
    logic [rbmc_pkg::CH_W-1:0]  out_red;
    logic [rbmc_pkg::CH_W-1:0]  out_green;
    logic [rbmc_pkg::CH_W-1:0]  out_blue;
    logic [rbmc_pkg::CH_W-1:0]  out_alpha;

    modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

interface rbmc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rbmc_pkg::CFG_IDX_W-1:0]  index;
    logic [rbmc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### design/rbmc_div.sv
// Pipelined restoring divider, four lanes, one quotient bit per stage.
// Depends on rbmc_pkg (div_lane_t, div_step) and the assertion macros.
`include "rgba_blend_mode_compositor_core_macros.svh"

module rbmc_div (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  rbmc_pkg::div_lane_t [rbmc_pkg::NUM_LANES-1:0] in_lanes,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output rbmc_pkg::div_lane_t [rbmc_pkg::NUM_LANES-1:0] out_lanes
);

    logic [rbmc_pkg::Q_STEPS-1:0] valid_reg;
    logic [rbmc_pkg::Q_STEPS-1:0] valid_next;
    logic [rbmc_pkg::Q_STEPS:0]   take;
    rbmc_pkg::div_lane_t [rbmc_pkg::NUM_LANES-1:0] lanes_reg  [rbmc_pkg::Q_STEPS];
    rbmc_pkg::div_lane_t [rbmc_pkg::NUM_LANES-1:0] lanes_next [rbmc_pkg::Q_STEPS];

    assign take[rbmc_pkg::Q_STEPS] = out_ready;

    // stage k settles quotient bit (Q_STEPS-1-k), MSB first
    for (genvar k = 0; k < rbmc_pkg::Q_STEPS; k++)
    begin : g_stage
        localparam logic [rbmc_pkg::POS_W-1:0] POS = rbmc_pkg::POS_W'(rbmc_pkg::Q_STEPS - 1 - k);

        assign take[k] = !valid_reg[k] || take[k+1];

        if (k == 0)
        begin : g_head
            assign valid_next[k] = in_valid;
            for (genvar l = 0; l < rbmc_pkg::NUM_LANES; l++)
            begin : g_lane
                assign lanes_next[k][l] = rbmc_pkg::div_step(in_lanes[l], POS);
            end
        end
        else
        begin : g_body
            assign valid_next[k] = valid_reg[k-1];
            for (genvar l = 0; l < rbmc_pkg::NUM_LANES; l++)
            begin : g_lane
                assign lanes_next[k][l] = rbmc_pkg::div_step(lanes_reg[k-1][l], POS);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (take[k])
            begin
                valid_reg[k] <= valid_next[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (take[k])
            begin
                lanes_reg[k] <= lanes_next[k];
            end
        end
    end

    assign in_ready  = take[0];
    assign out_valid = valid_reg[rbmc_pkg::Q_STEPS-1];
    assign out_lanes = lanes_reg[rbmc_pkg::Q_STEPS-1];

    `RBMC_ASSERT_IMPL(a_ready_when_empty, clk, rst_n, !valid_reg[0], in_ready)
    `RBMC_ASSERT_NEXT(a_stalled_head_kept, clk, rst_n, valid_reg[0] && !take[1], valid_reg[0])
    for (genvar l = 0; l < rbmc_pkg::NUM_LANES; l++)
    begin : g_chk
        `RBMC_ASSERT_IMPL(a_rem_below_den, clk, rst_n, out_valid && !out_lanes[l].fixed, out_lanes[l].rem < rbmc_pkg::N_W'(out_lanes[l].den))
    end

endmodule

### design/rgba_blend_mode_compositor_core.sv
// RGBA blend-mode compositor: top level with the five arithmetic stages.
// Depends on rbmc_pkg, rbmc_if.sv, rbmc_div and the assertion macros.
//
// Usage:
//   pixels    : valid/ready sink; one word is a destination and a source RGBA8 pixel.
//   composite : valid/ready source; one composited RGBA8 word per input word.
//   cfg       : valid/ready write port, always ready. Index 0 is blend_mode
//               (0 normal .. 6 lighten, 7 as normal), index 1 is layer_opacity.
//               Other indexes are ignored. Write only while the block is empty.
// Throughput: one word per clock while composite.ready stays high. The accepting
//   edge loads the first of thirteen register stages: five build the blend, alpha
//   and divider operands, then eight divider stages resolve one quotient bit each.
// Stalls: each stage holds its word while the next one is full and stalled,
//   and bubbles close up, so pixels.ready only drops once every stage is
//   full behind a stalled composite.ready. Nothing is dropped or repeated.
// Reset: rst_n clears all stage valid bits, sets blend_mode to normal and
//   layer_opacity to 255 (opaque).
`include "rgba_blend_mode_compositor_core_macros.svh"

module rgba_blend_mode_compositor_core (
    input  logic              clk,
    input  logic              rst_n,
    rbmc_in_if.sink           pixels,
    rbmc_out_if.source        composite,
    rbmc_cfg_if.sink          cfg
);

    typedef logic [rbmc_pkg::NUM_LANES-1:0][rbmc_pkg::CH_W-1:0]   pix_t;
    typedef logic [rbmc_pkg::COLOR_LANES-1:0][rbmc_pkg::B_W-1:0]  blend_vec_t;
    typedef logic [rbmc_pkg::COLOR_LANES-1:0][rbmc_pkg::DD_W-1:0] dd_vec_t;
    typedef logic [rbmc_pkg::COLOR_LANES-1:0][rbmc_pkg::P_W-1:0]  p_vec_t;
    typedef logic [rbmc_pkg::COLOR_LANES-1:0][rbmc_pkg::DR_W-1:0] dr_vec_t;

    typedef struct packed {
        pix_t                      dst;
        logic [rbmc_pkg::SA_W-1:0] sa;
        blend_vec_t                b;
        dd_vec_t                   dd;
    } s1_t;

    typedef struct packed {
        pix_t                      dst;
        logic                      pass;
        logic [rbmc_pkg::SA_W-1:0] sa;
        logic [rbmc_pkg::SA_W-1:0] rest;
        logic [rbmc_pkg::A_W-1:0]  sa255;
        blend_vec_t                b;
        dd_vec_t                   dd;
    } s2_t;

    typedef struct packed {
        pix_t                     dst;
        logic                     pass;
        logic [rbmc_pkg::A_W-1:0] a;
        p_vec_t                   bp;
        dr_vec_t                  dr;
    } s3_t;

    typedef struct packed {
        pix_t                        dst;
        logic                        pass;
        logic [rbmc_pkg::A_W-1:0]    a;
        logic [rbmc_pkg::A511_W-1:0] a511;
        p_vec_t                      p;
    } s4_t;

    // ---------------- configuration ----------------
    logic [rbmc_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [rbmc_pkg::CH_W-1:0]   opacity_reg, opacity_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        mode_next    = mode_reg;
        opacity_next = opacity_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                rbmc_pkg::REG_BLEND_MODE:    mode_next    = cfg.data[rbmc_pkg::MODE_W-1:0];
                rbmc_pkg::REG_LAYER_OPACITY: opacity_next = cfg.data[rbmc_pkg::CH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= rbmc_pkg::MODE_NORMAL;
            opacity_reg <= rbmc_pkg::OPACITY_RESET;
        end
        else
        begin
            mode_reg    <= mode_next;
            opacity_reg <= opacity_next;
        end
    end

    // ---------------- helpers ----------------
    function automatic logic [rbmc_pkg::B_W-1:0] x255(input logic [rbmc_pkg::B_W-1:0] v);
        return (v << 8) - v;
    endfunction

    // blend value in 1/255^2 units, two's complement
    function automatic logic [rbmc_pkg::B_W-1:0] blend(
        input logic [rbmc_pkg::MODE_W-1:0] mode,
        input logic [rbmc_pkg::CH_W-1:0]   d,
        input logic [rbmc_pkg::CH_W-1:0]   s
    );
        logic [rbmc_pkg::CH_W-1:0] ma;
        logic [rbmc_pkg::CH_W-1:0] mb;
        logic [rbmc_pkg::DD_W-1:0] prod;
        logic [rbmc_pkg::CH_W-1:0] lo;
        logic [rbmc_pkg::CH_W-1:0] hi;
        logic [rbmc_pkg::B_W-1:0]  r;
        // screen reuses the multiplier on the inverted channels
        ma   = (mode == rbmc_pkg::MODE_SCREEN) ? ~d : d;
        mb   = (mode == rbmc_pkg::MODE_SCREEN) ? ~s : s;
        prod = rbmc_pkg::DD_W'(ma) * rbmc_pkg::DD_W'(mb);
        lo   = (d < s) ? d : s;
        hi   = (d > s) ? d : s;
        case (mode)
            rbmc_pkg::MODE_MULTIPLY: r = rbmc_pkg::B_W'(prod);
            rbmc_pkg::MODE_SCREEN:   r = rbmc_pkg::B_W'(rbmc_pkg::FULL2) - rbmc_pkg::B_W'(prod);
            rbmc_pkg::MODE_ADD:      r = x255(rbmc_pkg::B_W'(d) + rbmc_pkg::B_W'(s));
            rbmc_pkg::MODE_SUBTRACT: r = x255(rbmc_pkg::B_W'(d) - rbmc_pkg::B_W'(s));
            rbmc_pkg::MODE_DARKEN:   r = x255(rbmc_pkg::B_W'(lo));
            rbmc_pkg::MODE_LIGHTEN:  r = x255(rbmc_pkg::B_W'(hi));
            default:                 r = x255(rbmc_pkg::B_W'(s));
        endcase
        return r;
    endfunction

    // ---------------- stage handshake ----------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic take1, take2, take3, take4, take5;
    logic div_in_ready;

    assign take5 = !s5_valid_reg || div_in_ready;
    assign take4 = !s4_valid_reg || take5;
    assign take3 = !s3_valid_reg || take4;
    assign take2 = !s2_valid_reg || take3;
    assign take1 = !s1_valid_reg || take2;
    assign pixels.ready = take1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (take1) s1_valid_reg <= pixels.valid;
            if (take2) s2_valid_reg <= s1_valid_reg;
            if (take3) s3_valid_reg <= s2_valid_reg;
            if (take4) s4_valid_reg <= s3_valid_reg;
            if (take5) s5_valid_reg <= s4_valid_reg;
        end
    end

    // ---------------- stage 1: scaled alpha, blend, d*da ----------------
    s1_t  s1_reg, s1_next;
    pix_t dst_in, src_in;

    assign dst_in[rbmc_pkg::LANE_RED]   = pixels.dst_red;
    assign dst_in[rbmc_pkg::LANE_GREEN] = pixels.dst_green;
    assign dst_in[rbmc_pkg::LANE_BLUE]  = pixels.dst_blue;
    assign dst_in[rbmc_pkg::LANE_ALPHA] = pixels.dst_alpha;
    assign src_in[rbmc_pkg::LANE_RED]   = pixels.src_red;
    assign src_in[rbmc_pkg::LANE_GREEN] = pixels.src_green;
    assign src_in[rbmc_pkg::LANE_BLUE]  = pixels.src_blue;
    assign src_in[rbmc_pkg::LANE_ALPHA] = pixels.src_alpha;

    always_comb
    begin
        s1_next.dst = dst_in;
        s1_next.sa  = rbmc_pkg::SA_W'(src_in[rbmc_pkg::LANE_ALPHA])
                    * rbmc_pkg::SA_W'(opacity_reg);
        for (int c = 0; c < rbmc_pkg::COLOR_LANES; c++)
        begin
            s1_next.b[c]  = blend(mode_reg, dst_in[c], src_in[c]);
            s1_next.dd[c] = rbmc_pkg::DD_W'(dst_in[c])
                          * rbmc_pkg::DD_W'(dst_in[rbmc_pkg::LANE_ALPHA]);
        end
    end

    // ---------------- stage 2: 1 - SA, 255*SA ----------------
    s2_t s2_reg, s2_next;

    always_comb
    begin
        s2_next.dst   = s1_reg.dst;
        s2_next.pass  = (s1_reg.sa == '0);
        s2_next.sa    = s1_reg.sa;
        s2_next.rest  = rbmc_pkg::FULL2 - s1_reg.sa;
        s2_next.sa255 = (rbmc_pkg::A_W'(s1_reg.sa) << 8) - rbmc_pkg::A_W'(s1_reg.sa);
        s2_next.b     = s1_reg.b;
        s2_next.dd    = s1_reg.dd;
    end

    // ---------------- stage 3: products ----------------
    s3_t s3_reg, s3_next;

    always_comb
    begin
        logic signed [rbmc_pkg::P_W-1:0] b_ext;
        logic signed [rbmc_pkg::P_W-1:0] sa_ext;
        s3_next.dst  = s2_reg.dst;
        s3_next.pass = s2_reg.pass;
        s3_next.a    = s2_reg.sa255
                     + rbmc_pkg::A_W'(s2_reg.dst[rbmc_pkg::LANE_ALPHA])
                     * rbmc_pkg::A_W'(s2_reg.rest);
        sa_ext = rbmc_pkg::P_W'($signed({1'b0, s2_reg.sa}));
        for (int c = 0; c < rbmc_pkg::COLOR_LANES; c++)
        begin
            b_ext         = rbmc_pkg::P_W'($signed(s2_reg.b[c]));
            s3_next.bp[c] = b_ext * sa_ext;
            s3_next.dr[c] = rbmc_pkg::DR_W'(s2_reg.dd[c]) * rbmc_pkg::DR_W'(s2_reg.rest);
        end
    end

    // ---------------- stage 4: P and 511*A ----------------
    s4_t s4_reg, s4_next;

    always_comb
    begin
        s4_next.dst  = s3_reg.dst;
        s4_next.pass = s3_reg.pass;
        s4_next.a    = s3_reg.a;
        s4_next.a511 = (rbmc_pkg::A511_W'(s3_reg.a) << 9) - rbmc_pkg::A511_W'(s3_reg.a);
        for (int c = 0; c < rbmc_pkg::COLOR_LANES; c++)
        begin
            s4_next.p[c] = s3_reg.bp[c] + rbmc_pkg::P_W'(s3_reg.dr[c]);
        end
    end

    // ---------------- stage 5: divider operands ----------------
    // round(P/A) = floor((2P + A) / 2A); it saturates once 2P >= 511*A.
    rbmc_pkg::div_lane_t [rbmc_pkg::NUM_LANES-1:0] s5_lanes_reg, s5_lanes_next;

    always_comb
    begin
        logic                    pos;
        logic [rbmc_pkg::P_W-1:0] two_p;
        for (int c = 0; c < rbmc_pkg::COLOR_LANES; c++)
        begin
            pos   = !s4_reg.p[c][rbmc_pkg::P_W-1] && (s4_reg.p[c] != '0);
            two_p = {s4_reg.p[c][rbmc_pkg::P_W-2:0], 1'b0};
            s5_lanes_next[c].rem = rbmc_pkg::N_W'(two_p) + rbmc_pkg::N_W'(s4_reg.a);
            s5_lanes_next[c].den = {s4_reg.a, 1'b0};
            if (s4_reg.pass)
            begin
                s5_lanes_next[c].fixed = 1'b1;
                s5_lanes_next[c].q     = s4_reg.dst[c];
            end
            else if (!pos)
            begin
                s5_lanes_next[c].fixed = 1'b1;
                s5_lanes_next[c].q     = '0;
            end
            else if (two_p >= rbmc_pkg::P_W'(s4_reg.a511))
            begin
                s5_lanes_next[c].fixed = 1'b1;
                s5_lanes_next[c].q     = '1;
            end
            else
            begin
                s5_lanes_next[c].fixed = 1'b0;
                s5_lanes_next[c].q     = '0;
            end
        end
        // alpha out = round(A / 65025), never above 255
        s5_lanes_next[rbmc_pkg::LANE_ALPHA].rem   = rbmc_pkg::N_W'({s4_reg.a, 1'b0})
                                                  + rbmc_pkg::N_W'(rbmc_pkg::FULL2);
        s5_lanes_next[rbmc_pkg::LANE_ALPHA].den   = rbmc_pkg::ALPHA_DEN;
        s5_lanes_next[rbmc_pkg::LANE_ALPHA].fixed = s4_reg.pass;
        s5_lanes_next[rbmc_pkg::LANE_ALPHA].q     = s4_reg.pass
                                                  ? s4_reg.dst[rbmc_pkg::LANE_ALPHA] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (take1) s1_reg       <= s1_next;
        if (take2) s2_reg       <= s2_next;
        if (take3) s3_reg       <= s3_next;
        if (take4) s4_reg       <= s4_next;
        if (take5) s5_lanes_reg <= s5_lanes_next;
    end

    // ---------------- divider and output ----------------
    rbmc_pkg::div_lane_t [rbmc_pkg::NUM_LANES-1:0] div_out;

    rbmc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s5_valid_reg),
        .in_ready  (div_in_ready),
        .in_lanes  (s5_lanes_reg),
        .out_valid (composite.valid),
        .out_ready (composite.ready),
        .out_lanes (div_out)
    );

    assign composite.out_red   = div_out[rbmc_pkg::LANE_RED].q;
    assign composite.out_green = div_out[rbmc_pkg::LANE_GREEN].q;
    assign composite.out_blue  = div_out[rbmc_pkg::LANE_BLUE].q;
    assign composite.out_alpha = div_out[rbmc_pkg::LANE_ALPHA].q;

    `RBMC_ASSERT_IMPL(a_alpha_nonzero, clk, rst_n, s4_valid_reg && !s4_reg.pass, s4_reg.a != '0)
    `RBMC_ASSERT_NEXT(a_stalled_s1_kept, clk, rst_n, s1_valid_reg && !take2, s1_valid_reg)
    `RBMC_ASSERT_IMPL(a_pass_all_fixed, clk, rst_n, s5_valid_reg && s5_lanes_reg[rbmc_pkg::LANE_ALPHA].fixed, s5_lanes_reg[rbmc_pkg::LANE_RED].fixed && s5_lanes_reg[rbmc_pkg::LANE_GREEN].fixed && s5_lanes_reg[rbmc_pkg::LANE_BLUE].fixed)

endmodule
